FILE: src/dpd_pkg.sv
// Shared constants, codes and controller/datapath types of the priority dispatcher.
package dpd_pkg;

    localparam int NUM_QUEUES    = 3;
    localparam int DEPTH         = 64;
    localparam int PRIORITY_BITS = 4;
    localparam int SEQ_BITS      = 16;

    localparam int TOTAL_SLOTS = NUM_QUEUES * DEPTH;
    localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int MEM_W       = PRIORITY_BITS + SEQ_BITS;

    // Fixed field widths of the request and response channels.
    localparam int OP_W     = 2;
    localparam int QSEL_W   = 2;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 3;
    localparam int SEQ_ID_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SERVE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_SERVED   = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INSERTED = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_ZERO    = 2'd0,
        SRC_COUNTER = 2'd1,
        SRC_BEST    = 2'd2
    } t_seq_src;

    typedef struct packed {
        logic     capture;
        logic     slot_clr;
        logic     slot_inc;
        logic     ins_write;
        logic     rd_issue;
        logic     best_clr;
        logic     srv_take;
        logic     clear_all;
        logic     load_out;
        t_status  res_status;
        t_seq_src seq_src;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    q_ok;
        logic    full;
        logic    sat;
        logic    q_empty;
        logic    slot_live;
        logic    slot_last;
        logic    out_free;
    } t_dp_stat;

endpackage

FILE: src/dpd_req_if.sv
// Request channel: opcode, queue select and priority with valid/ready.
interface dpd_req_if import dpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [QSEL_W-1:0] queue_sel;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, opcode, queue_sel, priority_req, input ready);
    modport sink   (input valid, opcode, queue_sel, priority_req, output ready);
endinterface

FILE: src/dpd_rsp_if.sv
// Response channel: status and sequence number with valid/ready.
interface dpd_rsp_if import dpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_ID_W-1:0] seq_id;

    modport source (output valid, status, seq_id, input ready);
    modport sink   (input valid, status, seq_id, output ready);
endinterface

FILE: src/dpd_dp.sv
// Datapath: entry memory, live bits, queue fill counts, sequence counter, search and output.
module dpd_dp import dpd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [QSEL_W-1:0]   i_queue_sel,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SEQ_ID_W-1:0] o_seq_id
);

    // Request registers
    t_opcode             r_op;
    logic [QSEL_W-1:0]   r_q;
    logic [PRIO_W-1:0]   r_prio;

    // Entry store: {priority, sequence}
    logic [MEM_W-1:0]    r_mem [TOTAL_SLOTS];
    logic [MEM_W-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic                r_rd_live;
    logic [SLOT_W-1:0]   r_rd_slot;

    logic [TOTAL_SLOTS-1:0] r_live;
    logic [CNT_W-1:0]    r_count [NUM_QUEUES];
    logic [SEQ_BITS-1:0] r_seq_ctr;
    logic [CNT_W-1:0]    r_slot;

    // Running best of the search
    logic                     r_best_vld;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [SEQ_BITS-1:0]      r_best_seq;
    logic [SLOT_W-1:0]        r_best_slot;

    logic                r_out_vld;
    t_status             r_out_status;
    logic [SEQ_ID_W-1:0] r_out_seq;

    logic [QIDX_W-1:0]        w_qidx;
    logic [SLOT_W-1:0]        w_slot;
    logic [ADDR_W-1:0]        w_addr;
    logic [ADDR_W-1:0]        w_best_addr;
    logic [SEQ_BITS-1:0]      w_seq_next;
    logic [PRIORITY_BITS-1:0] w_rd_prio;
    logic [SEQ_BITS-1:0]      w_rd_seq;
    logic                     w_better;
    logic                     w_out_free;
    logic [SEQ_ID_W-1:0]      w_out_seq;

    assign w_qidx      = QIDX_W'(r_q);
    assign w_slot      = r_slot[SLOT_W-1:0];
    assign w_addr      = ADDR_W'(32'(w_qidx) * 32'(DEPTH) + 32'(w_slot));
    assign w_best_addr = ADDR_W'(32'(w_qidx) * 32'(DEPTH) + 32'(r_best_slot));
    assign w_seq_next  = r_seq_ctr + SEQ_BITS'(1);
    assign w_rd_prio   = r_rd_data[MEM_W-1:SEQ_BITS];
    assign w_rd_seq    = r_rd_data[SEQ_BITS-1:0];
    assign w_out_free  = !r_out_vld || i_rsp_ready;

    assign w_better = !r_best_vld || (w_rd_prio > r_best_prio) ||
                      ((w_rd_prio == r_best_prio) && (w_rd_seq < r_best_seq));

    always_comb begin
        o_stat.op        = r_op;
        o_stat.q_ok      = (32'(r_q) < NUM_QUEUES);
        o_stat.full      = (r_count[w_qidx] == CNT_W'(DEPTH));
        o_stat.q_empty   = (r_count[w_qidx] == '0);
        o_stat.sat       = (r_seq_ctr == '1);
        o_stat.slot_live = r_live[w_addr];
        o_stat.slot_last = (r_slot == CNT_W'(DEPTH - 1));
        o_stat.out_free  = w_out_free;
    end

    always_comb begin
        case (i_cmd.seq_src)
            SRC_COUNTER: w_out_seq = SEQ_ID_W'(r_seq_ctr);
            SRC_BEST:    w_out_seq = SEQ_ID_W'(r_best_seq);
            default:     w_out_seq = '0;
        endcase
    end

    // Request capture and entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(i_opcode);
            r_q    <= i_queue_sel;
            r_prio <= i_priority_req;
        end
        if (i_cmd.ins_write) begin
            r_mem[w_addr] <= {PRIORITY_BITS'(r_prio), w_seq_next};
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[w_addr];
        end
        r_rd_live <= r_live[w_addr];
        r_rd_slot <= w_slot;
    end

    // Control state: live bits, counts, counter, search and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_seq_ctr  <= '0;
            r_slot     <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_count[q] <= '0;
            end
        end else begin
            r_rd_vld <= i_cmd.rd_issue;

            if (i_cmd.slot_clr) begin
                r_slot <= '0;
            end else if (i_cmd.slot_inc) begin
                r_slot <= r_slot + CNT_W'(1);
            end

            if (i_cmd.clear_all) begin
                r_live    <= '0;
                r_seq_ctr <= '0;
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    r_count[q] <= '0;
                end
            end else if (i_cmd.ins_write) begin
                r_live[w_addr]  <= 1'b1;
                r_seq_ctr       <= w_seq_next;
                r_count[w_qidx] <= r_count[w_qidx] + CNT_W'(1);
            end else if (i_cmd.srv_take) begin
                r_live[w_best_addr] <= 1'b0;
                r_count[w_qidx]     <= r_count[w_qidx] - CNT_W'(1);
            end

            if (i_cmd.best_clr) begin
                r_best_vld <= 1'b0;
            end else if (r_rd_vld && r_rd_live && w_better) begin
                r_best_vld <= 1'b1;
            end

            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Search payload and response payload
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && r_rd_live && w_better && !i_cmd.best_clr) begin
            r_best_prio <= w_rd_prio;
            r_best_seq  <= w_rd_seq;
            r_best_slot <= r_rd_slot;
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.res_status;
            r_out_seq    <= w_out_seq;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_seq_id    = r_out_seq;

endmodule

FILE: src/dpd_ctrl.sv
// Controller: sequences decode, free-slot scan, priority search and response.
module dpd_ctrl import dpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_SRV_SCAN,
        S_SRV_DRAIN,
        S_SRV_TAKE,
        S_FIN
    } t_state;

    t_state   r_state,      n_state;
    t_status  r_res_status, n_res_status;
    t_seq_src r_res_src,    n_res_src;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_src    = r_res_src;
        o_cmd        = '0;
        o_cmd.res_status = r_res_status;
        o_cmd.seq_src    = r_res_src;
        o_req_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.slot_clr = 1'b1;
                o_cmd.best_clr = 1'b1;
                n_res_src      = SRC_ZERO;
                n_state        = S_FIN;
                unique case (i_stat.op)
                    OP_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_res_status    = ST_CLEARED;
                    end
                    OP_INSERT: begin
                        if (!i_stat.q_ok || i_stat.full || i_stat.sat) begin
                            n_res_status = ST_DROPPED;
                        end else begin
                            n_state = S_INS_SCAN;
                        end
                    end
                    OP_SERVE: begin
                        if (!i_stat.q_ok || i_stat.q_empty) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_state = S_SRV_SCAN;
                        end
                    end
                    default: begin
                        n_res_status = ST_EMPTY;
                    end
                endcase
            end
            S_INS_SCAN: begin
                // The fill count guarantees a free slot before the end
                if (!i_stat.slot_live) begin
                    o_cmd.ins_write = 1'b1;
                    n_res_status    = ST_INSERTED;
                    n_res_src       = SRC_COUNTER;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_SRV_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_stat.slot_last) begin
                    n_state = S_SRV_DRAIN;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_SRV_DRAIN: begin
                n_state = S_SRV_TAKE;
            end
            S_SRV_TAKE: begin
                o_cmd.srv_take = 1'b1;
                n_res_status   = ST_SERVED;
                n_res_src      = SRC_BEST;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_EMPTY;
            r_res_src    <= SRC_ZERO;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_res_src    <= n_res_src;
        end
    end

endmodule

FILE: src/multi_queue_priority_dispatcher.sv
// Steps: decode, then a free-slot scan (insert) or a search, drain and take (serve), then the response.
// Throughput: one request at a time; the next is taken in the cycle after the previous result
//   is loaded into the output register; a serve is bound by the one-slot-per-cycle search
//   through the single read port of the entry memory.
// Reset: live bits, fill counts and the sequence counter clear at once; no clearing pass.
//   The entry memory is not cleared: a serve reads every slot, but only slots marked live are used.
module multi_queue_priority_dispatcher import dpd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpd_req_if.sink       i_req,
    dpd_rsp_if.source     o_rsp
);

    // Command and status between the controller and the datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller: accepts a request only when idle, then walks it through
    // decode, scan or search, and the response load.
    dpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: per-queue slots live in one entry memory addressed as
    // queue * DEPTH + slot. A serve reads every slot of the queue in turn
    // and keeps the highest priority, lowest sequence number seen so far.
    // The response register lets the result wait while the next request
    // is taken in.
    dpd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_opcode       (i_req.opcode),
        .i_queue_sel    (i_req.queue_sel),
        .i_priority_req (i_req.priority_req),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_seq_id       (o_rsp.seq_id)
    );

endmodule
